FILE: src/pfjt_pkg.sv
`timescale 1ns / 1ps
package pfjt_pkg;

	// Wrench targets held in registers; joints driven by the Jacobian rows
	localparam int NTARGET = 6;
	localparam int JOINTS  = 6;

	// Configuration register indexes (targets occupy indexes 0 to 5)
	localparam logic [2:0] REG_GAIN_PROP  = 3'd6;
	localparam logic [2:0] REG_GAIN_INTEG = 3'd7;

	// Reset values
	localparam logic signed [31:0] TARGET0_RST    = 32'sd327680;
	localparam logic [15:0]        GAIN_PROP_RST  = 16'd19661;
	localparam logic [15:0]        GAIN_INTEG_RST = 16'd9830;

	// Multiplier steps: two gain products, then one product per joint
	localparam logic [2:0] STEP_INTEG = 3'd0;
	localparam logic [2:0] STEP_PROP  = 3'd1;
	localparam logic [2:0] STEP_JNT0  = 3'd2;
	localparam logic [2:0] STEP_LAST  = 3'd7;

	typedef logic signed [42:0] wide_t;

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		if (v > 43'sh0007FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -43'sh00080000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Clamp to the signed 40-bit range
	function automatic logic signed [39:0] sat40(input wide_t v);
		logic signed [39:0] r;
		if (v > 43'sh007FFFFFFFFF)
			r = 40'sh7FFFFFFFFF;
		else if (v < -43'sh008000000000)
			r = 40'sh8000000000;
		else
			r = v[39:0];
		return r;
	endfunction

endpackage

FILE: src/pi_force_jacobian_torque.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// request   in_valid / in_stall     axis, force_measured, jac_c0..jac_c5
// result    out_valid / out_stall   joint_torque_0..joint_torque_5
// config    cfg_we                  cfg_index, cfg_data
//
// An item with a valid axis passes through the error state, then eight products on
// the one shared 33x25 multiplier, each formed in the multiply state and added and
// clamped in the add state; the last axis then enters the output state. An item whose
// axis is out of range is taken without holding the block and dropped. in_stall is high while an item is in work.
// The torque result sits in an output register; a stalled result holds the block
// on the last axis only. arst_n clears control state, integrators and accumulators.
module pi_force_jacobian_torque #(
	parameter int AXES = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          axis,
	input  logic signed [31:0]  force_measured,
	input  logic signed [23:0]  jac_c0,
	input  logic signed [23:0]  jac_c1,
	input  logic signed [23:0]  jac_c2,
	input  logic signed [23:0]  jac_c3,
	input  logic signed [23:0]  jac_c4,
	input  logic signed [23:0]  jac_c5,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  joint_torque_0,
	output logic signed [31:0]  joint_torque_1,
	output logic signed [31:0]  joint_torque_2,
	output logic signed [31:0]  joint_torque_3,
	output logic signed [31:0]  joint_torque_4,
	output logic signed [31:0]  joint_torque_5,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import pfjt_pkg::*;

	localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ERR  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic [2:0] jnt;
	logic [2:0] axis_q;
	logic [AXIS_W-1:0] ax_idx;
	logic signed [31:0] meas_q;
	logic signed [23:0] jac_q [JOINTS];
	logic signed [31:0] target_q [NTARGET];
	logic [15:0] gain_prop_q;
	logic [15:0] gain_integ_q;
	logic signed [31:0] integ_q [AXES];
	logic signed [39:0] acc_q [JOINTS];
	logic signed [32:0] err_q;
	logic signed [31:0] force_q;
	logic signed [57:0] prod_q;
	logic signed [31:0] tq_q [JOINTS];
	logic out_valid_q;

	logic accept;
	logic axis_ok;
	logic signed [31:0] target_sel;
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	wide_t sum;
	wide_t addend;
	logic out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign axis_ok  = (32'(axis) < AXES);
	assign ax_idx   = axis_q[AXIS_W-1:0];
	assign jnt      = step_q - STEP_JNT0;
	assign out_free = !out_valid_q || !out_stall;

	// Select the target of the current axis; axes past the registers aim at zero
	always_comb begin
		if (32'(axis_q) < NTARGET)
			target_sel = target_q[axis_q];
		else
			target_sel = '0;
	end

	// Choose operands for the shared multiplier
	always_comb begin
		unique case (step_q)
			STEP_INTEG: begin
				mul_a = err_q;
				mul_b = $signed({9'b0, gain_integ_q});
			end
			STEP_PROP: begin
				mul_a = err_q;
				mul_b = $signed({9'b0, gain_prop_q});
			end
			default: begin
				mul_a = 33'(force_q);
				mul_b = 25'(jac_q[jnt]);
			end
		endcase
	end

	// Pick what the scaled product is added to
	always_comb begin
		unique case (step_q)
			STEP_INTEG, STEP_PROP: addend = 43'(integ_q[ax_idx]);
			default:               addend = 43'(acc_q[jnt]);
		endcase
		sum = 43'($signed(prod_q[57:16])) + addend;
	end

	// Sequence the item through error, products and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_INTEG;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && axis_ok)
						state_q <= ST_ERR;
				end
				ST_ERR: begin
					step_q  <= STEP_INTEG;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (step_q == STEP_LAST) begin
						if (axis_q == 3'(AXES - 1))
							state_q <= ST_OUT;
						else
							state_q <= ST_IDLE;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q    <= axis;
			meas_q    <= force_measured;
			jac_q[0]  <= jac_c0;
			jac_q[1]  <= jac_c1;
			jac_q[2]  <= jac_c2;
			jac_q[3]  <= jac_c3;
			jac_q[4]  <= jac_c4;
			jac_q[5]  <= jac_c5;
		end
	end

	// Form the error, register each product and hold the clamped force command
	always_ff @(posedge clk) begin
		if (state_q == ST_ERR)
			err_q <= 33'(target_sel) - 33'(meas_q);
		if (state_q == ST_MUL)
			prod_q <= mul_a * mul_b;
		if (state_q == ST_ADD && step_q == STEP_PROP)
			force_q <= sat32(sum);
	end

	// Update the integral of the current axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++)
				integ_q[i] <= '0;
		end else if (state_q == ST_ADD && step_q == STEP_INTEG) begin
			integ_q[ax_idx] <= sat32(sum);
		end
	end

	// Clear the accumulators on axis 0, then add one joint per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++)
				acc_q[i] <= '0;
		end else if (state_q == ST_ERR && axis_q == 3'd0) begin
			for (int i = 0; i < JOINTS; i++)
				acc_q[i] <= '0;
		end else if (state_q == ST_ADD && step_q >= STEP_JNT0) begin
			acc_q[jnt] <= sat40(sum);
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q[0]  <= TARGET0_RST;
			for (int i = 1; i < NTARGET; i++)
				target_q[i] <= '0;
			gain_prop_q  <= GAIN_PROP_RST;
			gain_integ_q <= GAIN_INTEG_RST;
		end else if (cfg_we) begin
			priority if (cfg_index == REG_GAIN_PROP)
				gain_prop_q <= cfg_data[15:0];
			else if (cfg_index == REG_GAIN_INTEG)
				gain_integ_q <= cfg_data[15:0];
			else
				target_q[cfg_index] <= $signed(cfg_data);
		end
	end

	// Load the result register when it is free, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			for (int i = 0; i < JOINTS; i++)
				tq_q[i] <= sat32(43'(acc_q[i]));
		end
	end

	assign out_valid      = out_valid_q;
	assign joint_torque_0 = tq_q[0];
	assign joint_torque_1 = tq_q[1];
	assign joint_torque_2 = tq_q[2];
	assign joint_torque_3 = tq_q[3];
	assign joint_torque_4 = tq_q[4];
	assign joint_torque_5 = tq_q[5];

endmodule

FILE: src/pfjt_check.sv
`timescale 1ns / 1ps
module pfjt_check #(
	parameter int AXES = 6
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [2:0]         axis,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] joint_torque_0
);

	// A request on a live axis keeps the block busy
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (32'(axis) < AXES) |=> in_stall)
		else $error("block took a second request straight after a live axis");

	// A request on any axis but the last raises no result right after
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (32'(axis) != AXES - 1) |=> !$rose(out_valid))
		else $error("result raised straight after a request that cannot end a tick");

	// A request on an axis out of range is dropped at once
	a_drop_bad_axis: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (32'(axis) >= AXES) |=> !in_stall)
		else $error("request on an unused axis held the block");

	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(joint_torque_0))
		else $error("stalled result changed or vanished");

endmodule

bind pi_force_jacobian_torque pfjt_check #(.AXES(AXES)) u_pfjt_check (.*);

FILE: tb/tb_pi_force_jacobian_torque.sv
`timescale 1ns / 1ps
module tb_pi_force_jacobian_torque;
	import pfjt_pkg::*;

	localparam int         AXES         = 6;
	localparam logic [2:0] REG_TARGET0  = 3'd0;
	localparam int         CHUNK_ITEMS  = 210;
	localparam int         DRAIN_CYCLES = 48;
	localparam int         LONG_HOLD    = 600;
	localparam int         CYCLE_LIMIT  = 600000;
	localparam int         REPORT_LIMIT = 10;

	typedef logic [JOINTS-1:0][31:0] torque_set_t;

	typedef struct packed {
		logic [2:0]              ax;
		logic [31:0]             fmeas;
		logic [JOINTS-1:0][23:0] row;
	} axis_request_t;

	// Mirror of the force loop and torque accumulation, plus the queue of expected torque sets
	class torque_scoreboard;
		longint      target [NTARGET];
		logic [15:0] kp;
		logic [15:0] ki;
		longint      integ [AXES];
		longint      accum [JOINTS];
		torque_set_t pending [$];
		int          requests;
		int          dropped;
		int          results;
		int          failures;
		int          reports;

		function new();
			foreach (target[i]) target[i] = 0;
			target[0] = TARGET0_RST;
			kp = GAIN_PROP_RST;
			ki = GAIN_INTEG_RST;
			foreach (integ[i]) integ[i] = 0;
			foreach (accum[j]) accum[j] = 0;
			requests = 0;
			dropped  = 0;
			results  = 0;
			failures = 0;
			reports  = 0;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		// Mirror a register write; a gain write keeps only its low 16 bits
		function void write_reg(logic [2:0] idx, logic [31:0] data);
			if (idx == REG_GAIN_PROP)
				kp = data[15:0];
			else if (idx == REG_GAIN_INTEG)
				ki = data[15:0];
			else
				target[idx - REG_TARGET0] = longint'(signed'(data));
		endfunction

		function void note_request(axis_request_t r);
			longint      err;
			longint      pterm;
			longint      force_cmd;
			longint      prod;
			longint      clipped;
			torque_set_t want;
			// Drop an axis beyond the configured count without touching state
			if (r.ax >= AXES) begin
				dropped++;
				return;
			end
			requests++;
			err = ((r.ax < NTARGET) ? target[r.ax] : 64'sd0) - longint'(signed'(r.fmeas));
			integ[r.ax] = clamp(integ[r.ax] + ((longint'(ki) * err) >>> 16), 32);
			pterm = (longint'(kp) * err) >>> 16;
			force_cmd = clamp(pterm + integ[r.ax], 32);
			// Start a fresh tick on axis 0
			if (r.ax == 0)
				foreach (accum[j]) accum[j] = 0;
			for (int j = 0; j < JOINTS; j++) begin
				prod = (longint'(signed'(r.row[j])) * force_cmd) >>> 16;
				accum[j] = clamp(accum[j] + prod, 40);
			end
			if (r.ax == AXES - 1) begin
				for (int j = 0; j < JOINTS; j++) begin
					clipped = clamp(accum[j], 32);
					want[j] = clipped[31:0];
				end
				pending.push_back(want);
			end
		endfunction

		function void check_result(torque_set_t got);
			torque_set_t want;
			results++;
			if (pending.size() == 0) begin
				failures++;
				if (reports < REPORT_LIMIT)
					$display("unexpected torque set at %0t", $realtime);
				reports++;
				return;
			end
			want = pending.pop_front();
			for (int j = 0; j < JOINTS; j++) begin
				if (got[j] !== want[j]) begin
					failures++;
					if (reports < REPORT_LIMIT)
						$display("joint %0d torque mismatch at %0t: expected %0d, got %0d",
							j, $realtime, $signed(want[j]), $signed(got[j]));
					reports++;
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          axis;
	logic signed [31:0]  force_measured;
	logic signed [23:0]  jac_c0;
	logic signed [23:0]  jac_c1;
	logic signed [23:0]  jac_c2;
	logic signed [23:0]  jac_c3;
	logic signed [23:0]  jac_c4;
	logic signed [23:0]  jac_c5;
	logic                out_valid;
	logic                out_stall;
	logic signed [31:0]  joint_torque_0;
	logic signed [31:0]  joint_torque_1;
	logic signed [31:0]  joint_torque_2;
	logic signed [31:0]  joint_torque_3;
	logic signed [31:0]  joint_torque_4;
	logic signed [31:0]  joint_torque_5;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;

	torque_scoreboard sb = new();
	int               tx_idle_pct;
	int               rx_idle_pct;
	int               hold_requests;
	int               cycles;
	logic [31:0]      next_regs [8];

	pi_force_jacobian_torque #(.AXES(AXES)) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("pi_force_jacobian_torque verification failed");
		$finish;
	end

	// Stall results at random; on request hold off for a long stretch
	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Note each accepted request
	always @(posedge clk) begin : request_tap
		axis_request_t r;
		if (arst_n && in_valid && in_stall === 1'b0) begin
			r.ax    = axis;
			r.fmeas = force_measured;
			r.row   = {jac_c5, jac_c4, jac_c3, jac_c2, jac_c1, jac_c0};
			sb.note_request(r);
		end
	end

	// Check each accepted torque set
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_result({joint_torque_5, joint_torque_4, joint_torque_3,
				joint_torque_2, joint_torque_1, joint_torque_0});
	end

	// Mostly small values, sometimes full range or the signed extremes of the field
	function automatic logic [31:0] pick_value(int w, int unsigned span);
		logic [31:0] v;
		case ($urandom_range(15))
			0:       v = (32'h1 << (w - 1)) - 1;
			1:       v = 32'hFFFFFFFF << (w - 1);
			2, 3:    v = $urandom();
			default: v = $urandom_range(2 * span) - span;
		endcase
		return v;
	endfunction

	// Offer one request after an optional gap and hold it until taken
	task automatic send_item(logic [2:0] ax, logic [31:0] fmeas, logic [JOINTS-1:0][23:0] row);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		axis           <= ax;
		force_measured <= fmeas;
		jac_c0         <= row[0];
		jac_c1         <= row[1];
		jac_c2         <= row[2];
		jac_c3         <= row[3];
		jac_c4         <= row[4];
		jac_c5         <= row[5];
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic send_random(logic [2:0] ax);
		logic [JOINTS-1:0][23:0] row;
		for (int j = 0; j < JOINTS; j++)
			row[j] = 24'(pick_value(24, 1 << 17));
		send_item(ax, pick_value(32, 1 << 20), row);
	endtask

	// Whole ticks mostly, else partial ticks and stray axes
	task automatic run_chunk(int quota);
		int         counted;
		int         roll;
		int         k;
		logic [2:0] ax;
		counted = 0;
		while (counted < quota) begin
			roll = $urandom_range(99);
			if (roll < 85) begin
				for (int a = 0; a < AXES; a++)
					send_random(3'(a));
				counted += AXES;
			end else if (roll < 93) begin
				k = $urandom_range(AXES - 2);
				for (int a = 0; a <= k; a++)
					send_random(3'(a));
				counted += k + 1;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					ax = 3'($urandom_range(7));
					send_random(ax);
					if (ax < AXES)
						counted++;
				end
			end
		end
	endtask

	// Wait for every torque set, then let any result-free request finish
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings();
		for (int i = REG_TARGET0; i <= REG_GAIN_INTEG; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= next_regs[i];
			@(posedge clk);
			sb.write_reg(3'(i), next_regs[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [JOINTS-1:0][23:0] row;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		axis           = '0;
		force_measured = '0;
		jac_c0         = '0;
		jac_c1         = '0;
		jac_c2         = '0;
		jac_c3         = '0;
		jac_c4         = '0;
		jac_c5         = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		tx_idle_pct    = 12;
		rx_idle_pct    = 70;
		hold_requests  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One ordinary tick at the reset settings
		for (int a = 0; a < AXES; a++) begin
			for (int j = 0; j < JOINTS; j++)
				row[j] = 24'((j - 2) * 40000 + a * 1000);
			send_item(3'(a), 32'((a * 3 - 7) * 65536), row);
		end
		// Out-of-range axes carrying extreme values
		send_item(3'(AXES), 32'h7FFFFFFF, {JOINTS{24'h7FFFFF}});
		send_item(3'(AXES + 1), 32'h80000000, {JOINTS{24'h800000}});
		// Drive the integrators and accumulators into saturation both ways
		for (int a = 0; a < AXES; a++)
			send_item(3'(a), 32'h80000000, {JOINTS{24'h7FFFFF}});
		for (int a = 0; a < AXES; a++)
			send_item(3'(a), 32'h7FFFFFFF, {JOINTS{24'h800000}});
		// No axis 0: the accumulators carry on; also a repeated axis
		send_item(3'(AXES - 1), 32'h00000000, {JOINTS{24'h010000}});
		send_item(3'd3, 32'hFFFF0000, {3{24'h7FFFFF, 24'h800000}});
		send_item(3'd3, 32'hFFFF0000, {3{24'h7FFFFF, 24'h800000}});
		send_item(3'(AXES - 1), 32'h00050000, {JOINTS{24'hFFFFFF}});
		drain();

		for (int c = 0; c < 4; c++) begin
			case (c)
				0: begin
					next_regs[REG_TARGET0 + 0] = 32'h7FFFFFFF;
					next_regs[REG_TARGET0 + 1] = 32'h80000000;
					next_regs[REG_TARGET0 + 2] = 32'h00000000;
					next_regs[REG_TARGET0 + 3] = 32'hFFFFFFFF;
					next_regs[REG_TARGET0 + 4] = 32'h00050000;
					next_regs[REG_TARGET0 + 5] = 32'hFFFB0000;
					next_regs[REG_GAIN_PROP]   = {16'($urandom()), 16'hFFFF};
					next_regs[REG_GAIN_INTEG]  = {16'($urandom()), 16'hFFFF};
					tx_idle_pct = 12;
					rx_idle_pct = 70;
				end
				1: begin
					for (int i = 0; i < NTARGET; i++)
						next_regs[REG_TARGET0 + i] = $urandom();
					next_regs[REG_GAIN_PROP]  = {16'($urandom()), 16'h0000};
					next_regs[REG_GAIN_INTEG] = {16'($urandom()), 16'h0000};
					tx_idle_pct = 70;
					rx_idle_pct = 12;
				end
				default: begin
					for (int i = 0; i < NTARGET; i++)
						next_regs[REG_TARGET0 + i] = $urandom_range(2 << 20) - (1 << 20);
					next_regs[REG_GAIN_PROP]  = (c == 2) ? $urandom_range(65535) : 32'hFFFF;
					next_regs[REG_GAIN_INTEG] = (c == 2) ? $urandom_range(65535)
						: $urandom_range(1, 255);
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			load_settings();
			// Hold results back while requests keep coming, so the block backs up
			if (c >= 2)
				hold_requests++;
			run_chunk(CHUNK_ITEMS);
			drain();
		end

		$display("Covered %0d requests on valid axes and %0d dropped stray axes, %0d torque sets.",
			sb.requests, sb.dropped, sb.results);
		$display("Five register settings, three idle patterns, %0d long result hold-offs, %0d cycles.",
			hold_requests, cycles);
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("pi_force_jacobian_torque verification clean");
		else
			$display("pi_force_jacobian_torque verification failed");
		$finish;
	end

endmodule
